/* src/cdt_pkg.sv */
// Package for the countdown timer: transaction types, character codes, BCD helpers.
`timescale 1ns / 1ps

package cdt_pkg;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_SECOND = 1'b0;
  localparam logic CFG_BEEP_PERIOD      = 1'b1;

  localparam logic [23:0] TPS_RESET  = 24'd1000000;
  localparam logic [15:0] BEEP_RESET = 16'd5000;
  localparam logic [23:0] TICK_MAX   = 24'hFFFFFF;

  // Item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Character codes
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;
  localparam logic [7:0] CHR_ENTER = 8'd13;
  localparam logic [7:0] CHR_BKSP  = 8'd127;

  // Count after reset, as four BCD digits
  localparam logic [15:0] COUNT_RESET_BCD = 16'h9999;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_char;
    logic       key_held;
  } in_t;

  typedef struct packed {
    logic [13:0] count_value;
    logic [15:0] seg_thousands;
    logic [15:0] seg_hundreds;
    logic [15:0] seg_tens;
    logic [15:0] seg_units;
    logic        beep_pulse;
    logic        save_request;
    logic [13:0] pending_value;
    logic [2:0]  pending_digits;
  } out_t;

  // Seven-segment pattern word of one decimal digit
  function automatic logic [15:0] seg_of(input logic [3:0] d);
    logic [15:0] s;
    case (d)
      4'd0:    s = 16'b0101100010011000;
      4'd1:    s = 16'b0100000010000000;
      4'd2:    s = 16'b1001100010001000;
      4'd3:    s = 16'b1101000010001000;
      4'd4:    s = 16'b1100000010010000;
      4'd5:    s = 16'b1101000000011000;
      4'd6:    s = 16'b1101100000011000;
      4'd7:    s = 16'b0100000010001000;
      4'd8:    s = 16'b1101100010011000;
      4'd9:    s = 16'b1101000010011000;
      default: s = 16'b0101100010011000;
    endcase
    return s;
  endfunction

  // Four BCD digits to binary
  function automatic logic [13:0] bcd_to_bin(input logic [15:0] b);
    logic [13:0] v;
    v = 14'(b[15:12]) * 14'd1000 + 14'(b[11:8]) * 14'd100
      + 14'(b[7:4]) * 14'd10 + 14'(b[3:0]);
    return v;
  endfunction

  // Decrement four BCD digits by one; caller keeps the value nonzero
  function automatic logic [15:0] bcd_dec(input logic [15:0] b);
    logic [15:0] r;
    logic        borrow;
    r      = b;
    borrow = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (borrow) begin
        if (b[i*4 +: 4] == 4'd0) begin
          r[i*4 +: 4] = 4'd9;
        end else begin
          r[i*4 +: 4] = b[i*4 +: 4] - 4'd1;
          borrow      = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

/* src/countdown_timer_with_digit_entry_top.sv */
// Countdown timer with serial digit entry, tick timebase, alarm beep and segment words.
//
//   channel | signals                        | direction | notes
//   --------+--------------------------------+-----------+-------------------------------
//   in      | in_valid, in_ready, in_data    | input     | character or tick transaction
//   out     | out_valid, out_ready, out_data | output    | one result per input
//   cfg     | cfg_we, cfg_index, cfg_data    | input     | 0 ticks_per_second, 1 beep_period
//
// One transaction per cycle sustained while out_ready stays high; an input passes the input
// register, then the state update and result register in one pass.
// Reset (rst_n low, synchronous) empties both registers, restores the configuration
// defaults and sets the count to 9999.
// A stalled result holds out_data; in_ready drops only when both registers are full
// and out_ready is low.
`timescale 1ns / 1ps

module countdown_timer_with_digit_entry_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cdt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cdt_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [23:0]   cfg_data
);

  // Configuration
  logic [23:0] tps_r;
  logic [15:0] beep_period_r;

  // Timer state; count and entry are kept as BCD digits
  logic [15:0] count_bcd_r, count_bcd_nxt;
  logic [23:0] tick_r, tick_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [15:0] entry_bcd_r, entry_bcd_nxt;
  logic [2:0]  entry_digits_r, entry_digits_nxt;
  logic        armed_r, armed_nxt;

  // Pipeline registers
  cdt_pkg::in_t  in_r;
  logic          in_v_r;
  cdt_pkg::out_t out_r, out_nxt;
  logic          out_v_r;

  logic out_free;
  logic fire;
  logic beep, save;
  logic [23:0] tick_inc;
  logic [15:0] phase_inc;

  assign out_free  = !out_v_r || out_ready;
  assign fire      = in_v_r && out_free;
  assign in_ready  = !in_v_r || out_free;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r         <= cdt_pkg::TPS_RESET;
      beep_period_r <= cdt_pkg::BEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cdt_pkg::CFG_TICKS_PER_SECOND: tps_r         <= cfg_data;
        cdt_pkg::CFG_BEEP_PERIOD:      beep_period_r <= cfg_data[15:0];
        default:                       tps_r         <= tps_r;
      endcase
    end
  end

  // Advance the timer state for the registered transaction
  always_comb begin
    count_bcd_nxt    = count_bcd_r;
    tick_nxt         = tick_r;
    phase_nxt        = phase_r;
    entry_bcd_nxt    = entry_bcd_r;
    entry_digits_nxt = entry_digits_r;
    armed_nxt        = armed_r;
    beep             = 1'b0;
    save             = 1'b0;
    tick_inc         = (tick_r != cdt_pkg::TICK_MAX) ? tick_r + 24'd1 : tick_r;
    phase_inc        = phase_r + 16'd1;

    if (in_r.kind == cdt_pkg::KIND_CHAR) begin
      if (in_r.rx_char inside {[cdt_pkg::CHR_ZERO:cdt_pkg::CHR_NINE]}) begin
        // Append a digit while fewer than four are pending
        if (entry_digits_r < 3'd4) begin
          entry_bcd_nxt    = {entry_bcd_r[11:0], in_r.rx_char[3:0]};
          entry_digits_nxt = entry_digits_r + 3'd1;
        end
      end else if (in_r.rx_char == cdt_pkg::CHR_ENTER) begin
        // Load the count from the entry
        if (entry_digits_r != 3'd0) begin
          armed_nxt        = (entry_bcd_r == 16'h0000);
          tick_nxt         = 24'd0;
          phase_nxt        = 16'd0;
          count_bcd_nxt    = entry_bcd_r;
          entry_bcd_nxt    = 16'h0000;
          entry_digits_nxt = 3'd0;
        end
      end else if (in_r.rx_char == cdt_pkg::CHR_BKSP) begin
        // Drop the last typed digit
        if (entry_digits_r != 3'd0) begin
          entry_bcd_nxt    = {4'd0, entry_bcd_r[15:4]};
          entry_digits_nxt = entry_digits_r - 3'd1;
        end
      end
    end else begin
      tick_nxt  = tick_inc;
      phase_nxt = phase_inc;
      // Wrap the beep phase
      if (phase_inc >= beep_period_r) begin
        phase_nxt = 16'd0;
        beep      = armed_r && !in_r.key_held;
      end
      // Decrement once a second's worth of ticks has gone by
      if (tick_inc >= tps_r && count_bcd_r != 16'h0000) begin
        tick_nxt      = 24'd0;
        phase_nxt     = 16'd0;
        count_bcd_nxt = cdt_pkg::bcd_dec(count_bcd_r);
        save          = 1'b1;
        if (count_bcd_r == 16'h0001) begin
          armed_nxt = 1'b1;
        end
      end
    end
  end

  // Build the result from the updated state
  always_comb begin
    out_nxt.count_value    = cdt_pkg::bcd_to_bin(count_bcd_nxt);
    out_nxt.seg_thousands  = cdt_pkg::seg_of(count_bcd_nxt[15:12]);
    out_nxt.seg_hundreds   = cdt_pkg::seg_of(count_bcd_nxt[11:8]);
    out_nxt.seg_tens       = cdt_pkg::seg_of(count_bcd_nxt[7:4]);
    out_nxt.seg_units      = cdt_pkg::seg_of(count_bcd_nxt[3:0]);
    out_nxt.beep_pulse     = beep;
    out_nxt.save_request   = save;
    out_nxt.pending_value  = cdt_pkg::bcd_to_bin(entry_bcd_nxt);
    out_nxt.pending_digits = entry_digits_nxt;
  end

  // Hold state and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_bcd_r    <= cdt_pkg::COUNT_RESET_BCD;
      tick_r         <= 24'd0;
      phase_r        <= 16'd0;
      entry_bcd_r    <= 16'h0000;
      entry_digits_r <= 3'd0;
      armed_r        <= 1'b0;
      in_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (fire) begin
        count_bcd_r    <= count_bcd_nxt;
        tick_r         <= tick_nxt;
        phase_r        <= phase_nxt;
        entry_bcd_r    <= entry_bcd_nxt;
        entry_digits_r <= entry_digits_nxt;
        armed_r        <= armed_nxt;
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (out_free) begin
        out_v_r <= in_v_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule
